[rtl/lcp_sa_pkg.sv]
// ----------------------------------------------------------------------------
// LCP array package
// Shared constants, codes and the command and status types that join the
// controller and the datapath of the LCP array block.
// ----------------------------------------------------------------------------
package lcp_sa_pkg;

	// Default text capacity in positions.
	localparam int DEF_MAX_LEN = 4096;

	// Field widths of the request and result beats.
	localparam int TEXT_W = 8;
	localparam int POS_W  = 12;
	localparam int LEN_W  = 12;
	localparam int ERR_W  = 2;

	// Largest prefix length that a result can carry.
	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	// Request kinds.
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	// Result error codes.
	typedef enum logic [ERR_W-1:0] {
		ERR_OK           = 2'd0,
		ERR_RANGE        = 2'd1,
		ERR_OVERFLOW     = 2'd2,
		ERR_NOT_COMPUTED = 2'd3
	} err_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // store one text position
		logic clear_step;   // clear rank and prefix entry i
		logic rank_issue;   // read suffix entry i for the inverse rank
		logic walk_rank_rd; // read rank of text position i
		logic walk_top;     // top rank: prefix entry is zero, match length resets
		logic walk_jrd;     // read suffix entry at rank r+1
		logic cmp_issue;    // read both text bytes of the next compare
		logic cmp_inc;      // bytes matched: extend match length
		logic walk_write;   // write prefix entry, shorten match length
		logic finish;       // mark computed, give the completion result
		logic read_issue;   // start a read of one prefix entry
		logic read_emit;    // give the read result
	} lcp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_pos;  // index i is the last loaded position
		logic top_rank;  // rank r is the top rank
		logic in_bounds; // both compare positions lie inside the text
		logic text_eq;   // the two compared text bytes are equal
	} lcp_status_t;

endpackage

[rtl/lcp_sa_ram.sv]
// ----------------------------------------------------------------------------
// LCP array generic RAM
// Single write port, single read port, registered read data that holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module lcp_sa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/lcp_sa_ctrl.sv]
// ----------------------------------------------------------------------------
// LCP array controller
// State machine that sequences loading, the clearing pass, the inverse rank
// pass, the compare walk and single entry reads.
// ----------------------------------------------------------------------------
module lcp_sa_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     req_type,
	input  logic                     last_load,
	input  lcp_sa_pkg::lcp_status_t  status,
	output logic                     busy,
	output lcp_sa_pkg::lcp_cmd_t     cmd
);
	import lcp_sa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_CLEAR  = 10'b00_0000_0010,
		S_RANK   = 10'b00_0000_0100,
		S_FLUSH  = 10'b00_0000_1000,
		S_WRANK  = 10'b00_0001_0000,
		S_WCHECK = 10'b00_0010_0000,
		S_CISSUE = 10'b00_0100_0000,
		S_CTEST  = 10'b00_1000_0000,
		S_FINISH = 10'b01_0000_0000,
		S_READ   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_READ) begin
						cmd.read_issue = 1'b1;
						state_d        = S_READ;
					end else begin
						cmd.load = 1'b1;
						if (last_load) begin
							state_d = S_CLEAR;
						end
					end
				end
			end
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.last_pos) begin
					state_d = S_RANK;
				end
			end
			S_RANK: begin
				cmd.rank_issue = 1'b1;
				if (status.last_pos) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// The last rank write drains from the pipeline here.
				state_d = S_WRANK;
			end
			S_WRANK: begin
				cmd.walk_rank_rd = 1'b1;
				state_d          = S_WCHECK;
			end
			S_WCHECK: begin
				if (status.top_rank) begin
					cmd.walk_top = 1'b1;
					state_d      = status.last_pos ? S_FINISH : S_WRANK;
				end else begin
					cmd.walk_jrd = 1'b1;
					state_d      = S_CISSUE;
				end
			end
			S_CISSUE: begin
				if (status.in_bounds) begin
					cmd.cmp_issue = 1'b1;
					state_d       = S_CTEST;
				end else begin
					cmd.walk_write = 1'b1;
					state_d        = status.last_pos ? S_FINISH : S_WRANK;
				end
			end
			S_CTEST: begin
				if (status.text_eq) begin
					cmd.cmp_inc = 1'b1;
					state_d     = S_CISSUE;
				end else begin
					cmd.walk_write = 1'b1;
					state_d        = status.last_pos ? S_FINISH : S_WRANK;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_READ: begin
				cmd.read_emit = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[rtl/lcp_sa_dpath.sv]
// ----------------------------------------------------------------------------
// LCP array datapath
// Text, suffix, rank and prefix memories, the position index, the carried
// match length, session flags and the result registers.
// ----------------------------------------------------------------------------
module lcp_sa_dpath #(
	parameter int MAX_LEN = lcp_sa_pkg::DEF_MAX_LEN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lcp_sa_pkg::TEXT_W-1:0]     text_byte,
	input  logic [lcp_sa_pkg::POS_W-1:0]      suffix_pos,
	input  logic [lcp_sa_pkg::POS_W-1:0]      read_index,
	input  lcp_sa_pkg::lcp_cmd_t              cmd,
	output lcp_sa_pkg::lcp_status_t           status,
	output logic                              result_valid,
	output logic [lcp_sa_pkg::LEN_W-1:0]      prefix_len,
	output logic                              compute_done,
	output logic [lcp_sa_pkg::ERR_W-1:0]      error_code
);
	import lcp_sa_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Session and walk registers.
	logic [CW-1:0]    count_q;
	logic             overflow_q;
	logic             computed_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    k_q;
	logic             rk_v_s1;
	logic [AW-1:0]    rk_i_s1;
	err_t             rd_err_q;
	logic             res_valid_q;
	logic [LEN_W-1:0] res_len_q;
	logic             res_done_q;
	err_t             res_err_q;

	// Memory read data.
	logic [TEXT_W-1:0] ta_rdata;
	logic [TEXT_W-1:0] tb_rdata;
	logic [POS_W-1:0]  sfx_rdata;
	logic [AW-1:0]     rank_rdata;
	logic [LEN_W-1:0]  pre_rdata;

	// Derived values.
	logic [CW-1:0]    eff_count;
	logic             room;
	logic             store;
	logic [CW-1:0]    i_inc;
	logic             i_last;
	logic [CW-1:0]    rp1;
	logic [WW-1:0]    n_w;
	logic [WW-1:0]    ik;
	logic [WW-1:0]    jk;
	logic [WW-1:0]    k_w;
	logic [LEN_W-1:0] k_sat;
	logic             p_ok;
	logic             rd_in_range;

	// Memory port controls.
	logic              sfx_re;
	logic [AW-1:0]     sfx_raddr;
	logic              rank_we;
	logic [AW-1:0]     rank_waddr;
	logic [AW-1:0]     rank_wdata;
	logic              pre_we;
	logic [AW-1:0]     pre_waddr;
	logic [LEN_W-1:0]  pre_wdata;

	// A load after a finished computation opens a new session at position 0.
	assign eff_count = computed_q ? '0 : count_q;
	assign room      = (eff_count < CW'(MAX_LEN));
	assign store     = cmd.load && room;

	// Index and bound arithmetic.
	assign i_inc  = i_q + CW'(1);
	assign i_last = (i_inc == count_q);
	assign rp1    = CW'(rank_rdata) + CW'(1);
	assign n_w    = WW'(count_q);
	assign ik     = WW'(i_q) + WW'(k_q);
	assign jk     = WW'(sfx_rdata) + WW'(k_q);
	assign k_w    = WW'(k_q);
	assign k_sat  = (k_w > WW'(LEN_SAT)) ? LEN_SAT : k_w[LEN_W-1:0];
	assign p_ok   = (WW'(sfx_rdata) < n_w);
	assign rd_in_range = (WW'(read_index) < n_w);

	// Status to the controller.
	assign status.last_pos  = i_last;
	assign status.top_rank  = (rp1 >= count_q);
	assign status.in_bounds = (ik < n_w) && (jk < n_w);
	assign status.text_eq   = (ta_rdata == tb_rdata);

	// Suffix read port is shared by the rank pass and the walk.
	assign sfx_re    = cmd.rank_issue || cmd.walk_jrd;
	assign sfx_raddr = cmd.walk_jrd ? rp1[AW-1:0] : i_q[AW-1:0];

	// Rank writes: clearing pass, then the inverse rank from the pipeline.
	assign rank_we    = cmd.clear_step || (rk_v_s1 && p_ok);
	assign rank_waddr = cmd.clear_step ? i_q[AW-1:0] : AW'(sfx_rdata);
	assign rank_wdata = cmd.clear_step ? '0 : rk_i_s1;

	// Prefix writes: clearing pass, top rank and end of each compare.
	assign pre_we    = cmd.clear_step || cmd.walk_top || cmd.walk_write;
	assign pre_waddr = cmd.clear_step ? i_q[AW-1:0] : rank_rdata;
	assign pre_wdata = cmd.walk_write ? k_sat : '0;

	// Two text copies give both compare bytes in the same cycle.
	lcp_sa_ram #(.WIDTH(TEXT_W), .DEPTH(MAX_LEN)) u_text_a (
		.clk   (clk),
		.we    (store),
		.waddr (eff_count[AW-1:0]),
		.wdata (text_byte),
		.re    (cmd.cmp_issue),
		.raddr (ik[AW-1:0]),
		.rdata (ta_rdata)
	);

	lcp_sa_ram #(.WIDTH(TEXT_W), .DEPTH(MAX_LEN)) u_text_b (
		.clk   (clk),
		.we    (store),
		.waddr (eff_count[AW-1:0]),
		.wdata (text_byte),
		.re    (cmd.cmp_issue),
		.raddr (jk[AW-1:0]),
		.rdata (tb_rdata)
	);

	lcp_sa_ram #(.WIDTH(POS_W), .DEPTH(MAX_LEN)) u_suffix (
		.clk   (clk),
		.we    (store),
		.waddr (eff_count[AW-1:0]),
		.wdata (suffix_pos),
		.re    (sfx_re),
		.raddr (sfx_raddr),
		.rdata (sfx_rdata)
	);

	lcp_sa_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_rank (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.re    (cmd.walk_rank_rd),
		.raddr (i_q[AW-1:0]),
		.rdata (rank_rdata)
	);

	lcp_sa_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_prefix (
		.clk   (clk),
		.we    (pre_we),
		.waddr (pre_waddr),
		.wdata (pre_wdata),
		.re    (cmd.read_issue),
		.raddr (AW'(read_index)),
		.rdata (pre_rdata)
	);

	// Session state, walk index and match length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			computed_q <= 1'b0;
			i_q        <= '0;
			k_q        <= '0;
			rk_v_s1    <= 1'b0;
		end else begin
			rk_v_s1 <= cmd.rank_issue;
			if (cmd.load) begin
				i_q <= '0;
				k_q <= '0;
				if (computed_q) begin
					computed_q <= 1'b0;
					overflow_q <= 1'b0;
				end
				if (room) begin
					count_q <= eff_count + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.clear_step || cmd.rank_issue) begin
				i_q <= i_last ? '0 : i_inc;
			end
			if (cmd.walk_top) begin
				i_q <= i_inc;
				k_q <= '0;
			end
			if (cmd.cmp_inc) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.walk_write) begin
				i_q <= i_inc;
				if (k_q != '0) begin
					k_q <= k_q - CW'(1);
				end
			end
			if (cmd.finish) begin
				computed_q <= 1'b1;
			end
		end
	end

	// Rank pass pipeline: position index follows its suffix read.
	always_ff @(posedge clk) begin
		if (cmd.rank_issue) begin
			rk_i_s1 <= i_q[AW-1:0];
		end
	end

	// Read error is settled when the read is issued.
	always_ff @(posedge clk) begin
		if (cmd.read_issue) begin
			if (!computed_q) begin
				rd_err_q <= ERR_NOT_COMPUTED;
			end else if (!rd_in_range) begin
				rd_err_q <= ERR_RANGE;
			end else begin
				rd_err_q <= ERR_OK;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.finish || cmd.read_emit;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_len_q  <= '0;
			res_done_q <= 1'b1;
			res_err_q  <= overflow_q ? ERR_OVERFLOW : ERR_OK;
		end else if (cmd.read_emit) begin
			res_len_q  <= (rd_err_q == ERR_OK) ? pre_rdata : '0;
			res_done_q <= 1'b0;
			res_err_q  <= rd_err_q;
		end
	end

	assign result_valid = res_valid_q;
	assign prefix_len   = res_len_q;
	assign compute_done = res_done_q;
	assign error_code   = res_err_q;

endmodule

[rtl/lcp_array_from_suffix_array.sv]
// ----------------------------------------------------------------------------
// LCP array from suffix array
// Loads a text and its suffix array one position per beat, computes the
// longest common prefix array and serves single entry reads.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken when start is high and busy is low.
// A load beat (req_type 0) stores one text byte and one suffix entry and
// gives no result; busy stays low. The load beat with last_load set also
// starts the computation over the n loaded positions: a clearing pass, an
// inverse rank pass, then the compare walk, which reads the rank of each
// position, writes a zero entry at the top rank and otherwise compares text
// bytes from the carried match length until they differ or leave the text.
// The walk is bound by the single read port of each memory; busy is high
// throughout. It ends with a completion beat. A read beat (req_type 1)
// gives its result from the prefix memory's read register through the
// result registers. Each result is on the result ports for exactly one
// cycle with result_valid high; the receiver cannot stall it. Reset clears
// the session (nothing loaded, nothing computed) but not the memories.
module lcp_array_from_suffix_array #(
	parameter int MAX_LEN = lcp_sa_pkg::DEF_MAX_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [lcp_sa_pkg::TEXT_W-1:0] text_byte,
	input  logic [lcp_sa_pkg::POS_W-1:0]  suffix_pos,
	input  logic                          last_load,
	input  logic [lcp_sa_pkg::POS_W-1:0]  read_index,
	output logic                          result_valid,
	output logic [lcp_sa_pkg::LEN_W-1:0]  prefix_len,
	output logic                          compute_done,
	output logic [lcp_sa_pkg::ERR_W-1:0]  error_code
);
	import lcp_sa_pkg::*;

	lcp_cmd_t    cmd;
	lcp_status_t status;

	// Sequencer.
	lcp_sa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.last_load (last_load),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	// Memories and arithmetic.
	lcp_sa_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.suffix_pos   (suffix_pos),
		.read_index   (read_index),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.prefix_len   (prefix_len),
		.compute_done (compute_done),
		.error_code   (error_code)
	);

endmodule

[sim/lcp_array_from_suffix_array_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCP array from suffix array testbench
// Loads texts and their suffix arrays beat by beat, reads back the computed
// prefix lengths and checks every result beat against a Kasai predictor that
// runs alongside the block. Covers reads before and outside a computation,
// one-position texts, broken suffix orders and a long run of random sessions
// with random idling on the sender side.
// ----------------------------------------------------------------------------
module lcp_array_from_suffix_array_test;
	import lcp_sa_pkg::*;

	localparam int CAPACITY     = DEF_MAX_LEN;
	localparam int RANDOM_BEATS = 700;
	localparam int TAIL_CYCLES  = 40;

	// One result beat as the predictor expects it.
	typedef struct {
		logic [LEN_W-1:0] len;
		logic             done;
		err_t             err;
	} lcp_beat_t;

	// Block inputs, all known from time zero.
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              req_type   = REQ_LOAD;
	logic [TEXT_W-1:0] text_byte  = '0;
	logic [POS_W-1:0]  suffix_pos = '0;
	logic              last_load  = 1'b0;
	logic [POS_W-1:0]  read_index = '0;

	// Block outputs.
	logic              busy;
	logic              result_valid;
	logic [LEN_W-1:0]  prefix_len;
	logic              compute_done;
	logic [ERR_W-1:0]  error_code;

	lcp_array_from_suffix_array #(
		.MAX_LEN(CAPACITY)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.text_byte   (text_byte),
		.suffix_pos  (suffix_pos),
		.last_load   (last_load),
		.read_index  (read_index),
		.result_valid(result_valid),
		.prefix_len  (prefix_len),
		.compute_done(compute_done),
		.error_code  (error_code)
	);

	always #6 clk = ~clk;

	// Mirror of the block's session state.
	logic [TEXT_W-1:0] text_copy [CAPACITY];
	logic [POS_W-1:0]  order_copy[CAPACITY];
	int unsigned       rank_copy [CAPACITY];
	int unsigned       lcp_copy  [CAPACITY];
	int unsigned       stored_n     = 0;
	bit                dropped_load = 1'b0;
	bit                lcp_ready    = 1'b0;

	// Result beats still to come, oldest first.
	lcp_beat_t awaited_beats[$];

	// Text and suffix order of the session being planned.
	logic [TEXT_W-1:0] plan_text[$];
	logic [POS_W-1:0]  plan_order[$];

	int fail_count    = 0;
	int calm_left     = 0;
	int beat_count    = 0;
	int load_beats    = 0;
	int read_beats    = 0;
	int session_count = 0;
	int widest_text   = 0;
	int code_count[4] = '{0, 0, 0, 0};

	// Kasai's method over the mirrored session.
	task automatic build_lcp();
		int unsigned n, k, r, j, i, p;
		n = stored_n;
		k = 0;
		for (i = 0; i < n; i++) begin
			rank_copy[i] = 0;
			lcp_copy[i]  = 0;
		end
		for (i = 0; i < n; i++) begin
			p = order_copy[i];
			if (p < n)
				rank_copy[p] = i;
		end
		for (i = 0; i < n; i++) begin
			r = rank_copy[i];
			if (r + 1 >= n) begin
				lcp_copy[r] = 0;
				k = 0;
			end else begin
				j = order_copy[r + 1];
				while (i + k < n && j + k < n && text_copy[i + k] == text_copy[j + k])
					k++;
				lcp_copy[r] = k;
				if (k > 0)
					k--;
			end
		end
	endtask

	// Update the mirror for one accepted beat and queue the result it causes.
	task automatic predict_beat(input req_t kind, input logic [TEXT_W-1:0] tb,
			input logic [POS_W-1:0] sp, input logic lst, input logic [POS_W-1:0] ri);
		lcp_beat_t want;
		want.len  = '0;
		want.done = 1'b0;
		want.err  = ERR_OK;
		if (kind == REQ_LOAD) begin
			load_beats++;
			if (lcp_ready) begin
				stored_n     = 0;
				dropped_load = 1'b0;
				lcp_ready    = 1'b0;
			end
			if (stored_n < CAPACITY) begin
				text_copy[stored_n]  = tb;
				order_copy[stored_n] = sp;
				stored_n++;
			end else begin
				dropped_load = 1'b1;
			end
			if (!lst)
				return;
			build_lcp();
			lcp_ready = 1'b1;
			session_count++;
			if (stored_n > widest_text)
				widest_text = stored_n;
			want.done = 1'b1;
			want.err  = dropped_load ? ERR_OVERFLOW : ERR_OK;
		end else begin
			read_beats++;
			if (!lcp_ready)
				want.err = ERR_NOT_COMPUTED;
			else if (ri >= stored_n)
				want.err = ERR_RANGE;
			else
				want.len = (lcp_copy[ri] > LEN_SAT) ? LEN_SAT : lcp_copy[ri][LEN_W-1:0];
		end
		code_count[want.err]++;
		awaited_beats.push_back(want);
	endtask

	// Drive one request beat, wait until it is taken, then predict it.
	task automatic send_beat(input req_t kind, input logic [TEXT_W-1:0] tb,
			input logic [POS_W-1:0] sp, input logic lst, input logic [POS_W-1:0] ri);
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= kind;
		text_byte  <= tb;
		suffix_pos <= sp;
		last_load  <= lst;
		read_index <= ri;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_beat(kind, tb, sp, lst, ri);
		beat_count++;
	endtask

	task automatic send_load(input logic [TEXT_W-1:0] tb, input logic [POS_W-1:0] sp,
			input logic lst);
		send_beat(REQ_LOAD, tb, sp, lst, POS_W'($urandom_range(4095)));
	endtask

	task automatic send_read(input logic [POS_W-1:0] ri);
		send_beat(REQ_READ, TEXT_W'($urandom_range(255)), POS_W'($urandom_range(4095)),
			1'($urandom_range(1)), ri);
	endtask

	// Hold the sender off until every awaited result has arrived.
	task automatic wait_results_drained();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_beats.size() != 0)
			@(posedge clk);
	endtask

	// True when the planned suffix at a sorts before the one at b.
	function automatic bit suffix_less(input int a, input int b);
		int n, k;
		n = plan_text.size();
		k = 0;
		while (a + k < n && b + k < n && plan_text[a + k] == plan_text[b + k])
			k++;
		if (a + k < n && b + k < n)
			return plan_text[a + k] < plan_text[b + k];
		return a + k == n;
	endfunction

	// Sort the planned text's suffixes into a valid suffix order.
	task automatic build_suffix_order();
		int order[$];
		int i, j, cur;
		for (i = 0; i < plan_text.size(); i++) begin
			cur = i;
			j = order.size();
			while (j > 0 && suffix_less(cur, order[j - 1]))
				j--;
			order.insert(j, cur);
		end
		plan_order.delete();
		foreach (order[q])
			plan_order.push_back(POS_W'(order[q]));
	endtask

	// Load the planned session, with stray reads between loads if asked.
	task automatic send_session(input bit stray_reads);
		int i;
		for (i = 0; i < plan_text.size(); i++) begin
			if (stray_reads && $urandom_range(7) == 0)
				send_read(POS_W'($urandom_range(4095)));
			send_load(plan_text[i], plan_order[i], i == plan_text.size() - 1);
		end
	endtask

	// Reads right after reset find nothing computed.
	task automatic test_read_before_compute();
		send_read('0);
		send_read('1);
	endtask

	// A one-position text: the only entry is the top one.
	task automatic test_single_position();
		send_load(8'hFF, 12'h000, 1'b1);
		send_read(12'd0);
		send_read(12'd1);
	endtask

	// A short text with extreme bytes, a read in the middle of loading and
	// reads of every rank plus two outside the text.
	task automatic test_small_text();
		int r;
		plan_text = '{8'h80, 8'hFF, 8'h80, 8'hFF, 8'h00};
		build_suffix_order();
		send_load(plan_text[0], plan_order[0], 1'b0);
		send_load(plan_text[1], plan_order[1], 1'b0);
		send_read(12'd0);
		for (r = 2; r < plan_text.size(); r++)
			send_load(plan_text[r], plan_order[r], r == plan_text.size() - 1);
		for (r = 0; r <= plan_text.size(); r++)
			send_read(POS_W'(r));
		send_read('1);
	endtask

	// A suffix order with a duplicate and an entry past the text.
	task automatic test_broken_order();
		int r;
		send_load(8'hFF, 12'hFFF, 1'b0);
		send_load(8'h00, 12'h000, 1'b0);
		send_load(8'hFF, 12'h000, 1'b1);
		for (r = 0; r < 4; r++)
			send_read(POS_W'(r));
	endtask

	// Random sessions: mostly valid texts with sentinels and true suffix
	// orders, the rest broken texts and orders, each followed by reads.
	task automatic test_random_sessions();
		int first_beat, n, i, mode, letters, reads;
		bit calm_done;
		first_beat = beat_count;
		calm_done  = 1'b0;
		while (beat_count - first_beat < RANDOM_BEATS) begin
			if (!calm_done && beat_count - first_beat > 250) begin
				calm_left = 150;
				calm_done = 1'b1;
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
			mode = $urandom_range(99);
			plan_text.delete();
			plan_order.delete();
			if (mode < 75) begin
				letters = $urandom_range(3);
				for (i = 0; i < n - 1; i++)
					plan_text.push_back((letters == 0) ? TEXT_W'($urandom_range(1, 255))
						: TEXT_W'(8'h61 + $urandom_range(letters)));
				plan_text.push_back(8'h00);
				build_suffix_order();
			end else begin
				for (i = 0; i < n; i++) begin
					plan_text.push_back(TEXT_W'($urandom_range(255)));
					plan_order.push_back(($urandom_range(1) == 0)
						? POS_W'($urandom_range(4095)) : POS_W'($urandom_range(n + 1)));
				end
			end
			send_session(mode >= 75 || $urandom_range(7) == 0);
			reads = $urandom_range(1, 8);
			for (i = 0; i < reads; i++)
				send_read(($urandom_range(4) == 0) ? POS_W'($urandom_range(4095))
					: POS_W'($urandom_range(n)));
			if ($urandom_range(5) == 0)
				wait_results_drained();
		end
	endtask

	// Compare each result beat with the oldest awaited one.
	always @(posedge clk) begin : check_results
		lcp_beat_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (awaited_beats.size() == 0) begin
				$display("%0t: result beat with none awaited: prefix_len %0d done %0b err %0d",
					$time, prefix_len, compute_done, error_code);
				fail_count++;
			end else begin
				want = awaited_beats.pop_front();
				if (prefix_len !== want.len) begin
					$display("%0t: prefix_len expected %0d, got %0d", $time, want.len,
						prefix_len);
					fail_count++;
				end
				if (compute_done !== want.done) begin
					$display("%0t: compute_done expected %0b, got %0b", $time, want.done,
						compute_done);
					fail_count++;
				end
				if (error_code !== want.err) begin
					$display("%0t: error_code expected %0d, got %0d", $time, want.err,
						error_code);
					fail_count++;
				end
			end
		end
	end

	// Hard limit on the run.
	initial begin
		#12_000_000;
		$display("lcp_array_from_suffix_array test failed");
		$finish;
	end

	// Reset, directed tests, random sessions, then the final verdict.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_before_compute();
		test_single_position();
		test_small_text();
		test_broken_order();
		test_random_sessions();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_beats.size() != 0) begin
			$display("%0t: %0d result beats never arrived", $time, awaited_beats.size());
			fail_count++;
		end
		$display("Ran %0d sessions of up to %0d positions with %0d load and %0d read beats.",
			session_count, widest_text, load_beats, read_beats);
		$display("Awaited codes: %0d ok, %0d out of range, %0d overflow, %0d not computed.",
			code_count[ERR_OK], code_count[ERR_RANGE], code_count[ERR_OVERFLOW],
			code_count[ERR_NOT_COMPUTED]);
		if (fail_count == 0)
			$display("lcp_array_from_suffix_array test passed");
		else
			$display("lcp_array_from_suffix_array test failed");
		$finish;
	end

endmodule

[files.f]
rtl/lcp_sa_pkg.sv
rtl/lcp_sa_ram.sv
rtl/lcp_sa_ctrl.sv
rtl/lcp_sa_dpath.sv
rtl/lcp_array_from_suffix_array.sv
sim/lcp_array_from_suffix_array_test.sv
